/* src/tlpt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the two-level page table engine.
package tlpt_pkg;

	localparam int DIR_ENTRIES  = 1024;
	localparam int PAGE_ENTRIES = 1024;
	localparam int IDX_W        = 10;
	localparam int OFS_W        = 12;
	localparam int FRAME_W      = 20;
	localparam int VA_W         = 32;
	localparam int DIR_SHIFT    = 22;
	localparam int PAGE_SHIFT   = 12;

	localparam logic [VA_W-1:0] LOAD_OFFSET_RST = 32'hC000_0000;

	typedef enum logic [1:0] {
		OP_TRANSLATE = 2'd0,
		OP_MAP       = 2'd1,
		OP_UNMAP     = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STS_OK          = 2'd0,
		STS_NO_TABLE    = 2'd1,
		STS_NOT_PRESENT = 2'd2,
		STS_POOL_FULL   = 2'd3
	} status_t;

	typedef enum logic {
		CFG_PAGING_ON  = 1'b0,
		CFG_LOAD_OFFSET = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIR,
		ST_ENT
	} state_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               present;
		logic               rw;
		logic               user;
	} entry_t;

endpackage

/* src/tlpt_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
module tlpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/two_level_page_table_engine.sv */
`timescale 1ns / 1ps
// Two-level page table engine: a request passes through ST_DIR, for the directory
// memory read (and table allocation), and ST_ENT, for the page entry memory read with
// its write-back; a new request is taken in the cycle its predecessor completes.
// The result sits in an output register; when that register is still full a
// request holds in its last cycle. After reset a clearing pass writes zero to
// every page entry, one a cycle, and to every directory entry alongside the first
// 1024 of them, before the first request is taken; configuration writes are taken
// at any time.
module two_level_page_table_engine #(
	parameter int TABLE_POOL = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  tlpt_pkg::cfg_idx_t cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] vaddr,
	input  logic [19:0] frame_number,
	input  logic        rw_flag,
	input  logic        user_flag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] paddr,
	output logic        rw_out,
	output logic        user_out,
	output logic [19:0] old_frame,
	output logic        old_valid
);
	import tlpt_pkg::*;

	localparam int SLOT_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
	localparam int NS_W      = $clog2(TABLE_POOL + 1);
	localparam int ENT_DEPTH = TABLE_POOL * PAGE_ENTRIES;
	localparam int EADDR_W   = $clog2(ENT_DEPTH);
	localparam int CLR_W     = EADDR_W + 1;
	localparam int DIR_W     = SLOT_W + 1;
	localparam int ENT_W     = $bits(entry_t);

	state_t state_q, state_d;

	logic               paging_q;
	logic [VA_W-1:0]    load_offset_q;
	logic [CLR_W-1:0]   clr_q;
	logic [NS_W-1:0]    next_slot_q;

	op_t                op_q;
	logic [VA_W-1:0]    va_q;
	logic [FRAME_W-1:0] fr_q;
	logic               rw_q;
	logic               us_q;

	logic               present_s2;
	logic               full_s2;
	logic [EADDR_W-1:0] ent_addr_s2;

	logic               accept;
	logic               clr_last;
	logic               out_free;
	logic               advance;

	logic               dir_we;
	logic [IDX_W-1:0]   dir_waddr;
	logic [DIR_W-1:0]   dir_wdata;
	logic               dir_re;
	logic [DIR_W-1:0]   dir_rdata;

	logic               ent_we;
	logic [EADDR_W-1:0] ent_waddr;
	entry_t             ent_wdata;
	logic               ent_re;
	entry_t             ent_rdata;
	logic [ENT_W-1:0]   ent_rbits;

	logic               dir_present;
	logic [SLOT_W-1:0]  slot_sel;
	logic               alloc;
	logic               pool_full;
	logic [SLOT_W+IDX_W-1:0] ent_full_addr;

	status_t            res_status;
	logic [VA_W-1:0]    res_paddr;
	logic               res_rw;
	logic               res_user;
	logic [FRAME_W-1:0] res_old_frame;
	logic               res_old_valid;

	assign accept   = in_valid && in_ready;
	assign clr_last = (clr_q == CLR_W'(ENT_DEPTH - 1));
	assign out_free = !out_valid || out_ready;
	assign advance  = (state_q == ST_ENT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DIR;
				end
			end
			ST_DIR: begin
				state_d = ST_ENT;
			end
			ST_ENT: begin
				if (out_free) begin
					in_ready = 1'b1;
					state_d  = in_valid ? ST_DIR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q      <= 1'b0;
			load_offset_q <= LOAD_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGING_ON:   paging_q      <= cfg_wdata[0];
				CFG_LOAD_OFFSET: load_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR && !clr_last) begin
			clr_q <= clr_q + CLR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(op);
			va_q <= vaddr;
			fr_q <= frame_number;
			rw_q <= rw_flag;
			us_q <= user_flag;
		end
	end

	// directory stage
	assign dir_present   = dir_rdata[DIR_W-1];
	assign pool_full     = (next_slot_q >= NS_W'(TABLE_POOL));
	assign alloc         = (state_q == ST_DIR) && (op_q == OP_MAP) && !dir_present && !pool_full;
	assign slot_sel      = dir_present ? dir_rdata[SLOT_W-1:0] : next_slot_q[SLOT_W-1:0];
	assign ent_full_addr = {slot_sel, va_q[PAGE_SHIFT +: IDX_W]};
	assign dir_re        = accept;
	assign ent_re        = (state_q == ST_DIR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_slot_q <= '0;
		end else if (alloc) begin
			next_slot_q <= next_slot_q + NS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIR) begin
			present_s2  <= dir_present || alloc;
			full_s2     <= (op_q == OP_MAP) && !dir_present && pool_full;
			ent_addr_s2 <= ent_full_addr[EADDR_W-1:0];
		end
	end

	always_comb begin
		dir_we    = 1'b0;
		dir_waddr = va_q[DIR_SHIFT +: IDX_W];
		dir_wdata = {1'b1, slot_sel};
		if (state_q == ST_CLEAR) begin
			dir_we    = (clr_q < CLR_W'(DIR_ENTRIES));
			dir_waddr = clr_q[IDX_W-1:0];
			dir_wdata = '0;
		end else if (alloc) begin
			dir_we = 1'b1;
		end
	end

	// entry stage
	assign ent_rdata = entry_t'(ent_rbits);

	always_comb begin
		res_status    = STS_OK;
		res_paddr     = '0;
		res_rw        = 1'b0;
		res_user      = 1'b0;
		res_old_frame = '0;
		res_old_valid = 1'b0;
		ent_we        = 1'b0;
		ent_waddr     = ent_addr_s2;
		ent_wdata     = '0;
		if (state_q == ST_CLEAR) begin
			ent_we    = 1'b1;
			ent_waddr = clr_q[EADDR_W-1:0];
		end else begin
			unique case (op_q)
				OP_TRANSLATE: begin
					if (!paging_q) begin
						res_paddr = va_q - load_offset_q;
					end else if (!present_s2) begin
						res_status = STS_NO_TABLE;
					end else if (!ent_rdata.present) begin
						res_status = STS_NOT_PRESENT;
					end else begin
						res_paddr = {ent_rdata.frame, va_q[OFS_W-1:0]};
						res_rw    = ent_rdata.rw;
						res_user  = ent_rdata.user;
					end
				end
				OP_MAP: begin
					if (full_s2) begin
						res_status = STS_POOL_FULL;
					end else begin
						ent_we            = advance;
						ent_wdata.frame   = fr_q;
						ent_wdata.present = 1'b1;
						ent_wdata.rw      = rw_q;
						ent_wdata.user    = us_q;
						res_old_valid     = ent_rdata.present;
						res_old_frame     = ent_rdata.present ? ent_rdata.frame : '0;
					end
				end
				OP_UNMAP: begin
					if (!present_s2) begin
						res_status = STS_NO_TABLE;
					end else if (!ent_rdata.present) begin
						res_status = STS_NOT_PRESENT;
					end else begin
						ent_we        = advance;
						res_old_frame = ent_rdata.frame;
						res_old_valid = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status    <= res_status;
			paddr     <= res_paddr;
			rw_out    <= res_rw;
			user_out  <= res_user;
			old_frame <= res_old_frame;
			old_valid <= res_old_valid;
		end
	end

	tlpt_ram #(
		.WIDTH (DIR_W),
		.DEPTH (DIR_ENTRIES)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (dir_re),
		.raddr (vaddr[DIR_SHIFT +: IDX_W]),
		.rdata (dir_rdata)
	);

	tlpt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENT_DEPTH)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_full_addr[EADDR_W-1:0]),
		.rdata (ent_rbits)
	);

`ifndef NO_ASSERTIONS
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_slot_q <= NS_W'(TABLE_POOL))
		else $error("table pool counter past pool size");

	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIR))
		else $error("accepted request did not start directory read");

	a_ent_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> (state_q == ST_CLEAR || advance))
		else $error("entry write outside clear or completion");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STS_OK) |-> (paddr == '0 && !old_valid))
		else $error("failed request carries address or old frame");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!in_ready && !out_valid))
		else $error("request path active during clearing pass");
`endif

endmodule

/* tb/page_walk_checker.sv */
`timescale 1ns / 1ps
// Checker of the page table engine: mirrors the tables, predicts each result and compares it.
module page_walk_checker #(
	parameter int TABLE_POOL = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  tlpt_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         op,
	input  logic [31:0]        vaddr,
	input  logic [19:0]        frame_number,
	input  logic               rw_flag,
	input  logic               user_flag,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic [31:0]        paddr,
	input  logic               rw_out,
	input  logic               user_out,
	input  logic [19:0]        old_frame,
	input  logic               old_valid,
	output int                 mismatches,
	output int                 outstanding
);
	import tlpt_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [31:0]        paddr;
		logic               rw;
		logic               user;
		logic [FRAME_W-1:0] frame;
		logic               released;
	} walk_result_t;

	logic         walking_enabled;
	logic [31:0]  base_offset;
	logic         table_owned [DIR_ENTRIES];
	int           table_slot [DIR_ENTRIES];
	entry_t       pte_store [TABLE_POOL*PAGE_ENTRIES];
	int           slots_used;
	walk_result_t due_results [$];

	function automatic walk_result_t walk_tables(input logic [1:0] req_op,
			input logic [31:0] va, input logic [19:0] fr, input logic rw, input logic us);
		walk_result_t r;
		int           di;
		int           ti;
		int           pos;
		entry_t       e;
		r = '0;
		di = int'(va[31:22]);
		ti = int'(va[21:12]);
		case (req_op)
		OP_TRANSLATE: begin
			if (!walking_enabled) begin
				r.paddr = va - base_offset;
			end else if (!table_owned[di]) begin
				r.status = STS_NO_TABLE;
			end else begin
				e = pte_store[table_slot[di]*PAGE_ENTRIES + ti];
				if (!e.present) begin
					r.status = STS_NOT_PRESENT;
				end else begin
					r.paddr = {e.frame, va[11:0]};
					r.rw = e.rw;
					r.user = e.user;
				end
			end
		end
		OP_MAP: begin
			if (!table_owned[di] && slots_used >= TABLE_POOL) begin
				r.status = STS_POOL_FULL;
			end else begin
				if (!table_owned[di]) begin
					table_slot[di] = slots_used;
					table_owned[di] = 1'b1;
					slots_used++;
				end
				pos = table_slot[di]*PAGE_ENTRIES + ti;
				e = pte_store[pos];
				if (e.present) begin
					r.frame = e.frame;
					r.released = 1'b1;
				end
				pte_store[pos] = {fr, 1'b1, rw, us};
			end
		end
		OP_UNMAP: begin
			if (!table_owned[di]) begin
				r.status = STS_NO_TABLE;
			end else begin
				pos = table_slot[di]*PAGE_ENTRIES + ti;
				e = pte_store[pos];
				if (!e.present) begin
					r.status = STS_NOT_PRESENT;
				end else begin
					pte_store[pos] = '0;
					r.frame = e.frame;
					r.released = 1'b1;
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		walk_result_t want;
		if (!arst_n) begin
			walking_enabled = 1'b0;
			base_offset = LOAD_OFFSET_RST;
			slots_used = 0;
			for (int i = 0; i < DIR_ENTRIES; i++)
				table_owned[i] = 1'b0;
			for (int i = 0; i < TABLE_POOL*PAGE_ENTRIES; i++)
				pte_store[i] = '0;
			due_results.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual status %h paddr %h",
						$time, status, paddr);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("paddr", want.paddr, paddr);
					check_field("rw_out", 32'(want.rw), 32'(rw_out));
					check_field("user_out", 32'(want.user), 32'(user_out));
					check_field("old_frame", 32'(want.frame), 32'(old_frame));
					check_field("old_valid", 32'(want.released), 32'(old_valid));
				end
			end
			if (in_valid && in_ready)
				due_results.push_back(walk_tables(op, vaddr, frame_number, rw_flag, user_flag));
			if (cfg_we) begin
				case (cfg_index)
				CFG_PAGING_ON: walking_enabled = cfg_wdata[0];
				CFG_LOAD_OFFSET: base_offset = cfg_wdata;
				default: ;
				endcase
			end
			outstanding = due_results.size();
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top of the page table engine: clock, reset, request and result traffic, verdict.
module tb_top;
	import tlpt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_MAX         = 14;
	localparam int LONG_HOLD        = 400;
	localparam int HOLD_AT          = 150;
	localparam int RANDOM_PER_PHASE = 345;
	localparam int SETTLE_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT   = 80000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	cfg_idx_t    cfg_index;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [31:0] vaddr;
	logic [19:0] frame_number;
	logic        rw_flag;
	logic        user_flag;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] paddr;
	logic        rw_out;
	logic        user_out;
	logic [19:0] old_frame;
	logic        old_valid;

	logic        no_idle;
	int          mismatches;
	int          outstanding;
	int          quiet_cycles;
	int          rx_wait;
	int          rx_count;
	bit          rx_held;

	two_level_page_table_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .vaddr(vaddr), .frame_number(frame_number),
		.rw_flag(rw_flag), .user_flag(user_flag),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .paddr(paddr), .rw_out(rw_out), .user_out(user_out),
		.old_frame(old_frame), .old_valid(old_valid)
	);

	page_walk_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .vaddr(vaddr), .frame_number(frame_number),
		.rw_flag(rw_flag), .user_flag(user_flag),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .paddr(paddr), .rw_out(rw_out), .user_out(user_out),
		.old_frame(old_frame), .old_valid(old_valid),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_req(input logic [1:0] req_op, input logic [31:0] req_va,
			input logic [19:0] req_frame, input logic req_rw, input logic req_user);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= req_op;
		vaddr <= req_va;
		frame_number <= req_frame;
		rw_flag <= req_rw;
		user_flag <= req_user;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_random;
		logic [1:0]  r_op;
		logic [31:0] r_va;
		logic [9:0]  di;
		logic [9:0]  ti;
		int          k;
		if ($urandom_range(0, 99) < 8) begin
			r_op = 2'($urandom_range(0, 3));
			r_va = $urandom;
		end else begin
			k = $urandom_range(0, 99);
			if (k < 40)
				r_op = OP_TRANSLATE;
			else if (k < 75)
				r_op = OP_MAP;
			else if (k < 97)
				r_op = OP_UNMAP;
			else
				r_op = OP_UNUSED;
			k = $urandom_range(0, 19);
			di = (k >= 18) ? 10'(1004 + k) : 10'(k);
			if ($urandom_range(0, 7) == 0)
				ti = {10{$urandom_range(0, 1) == 1}};
			else
				ti = 10'($urandom_range(0, 15));
			r_va = {di, ti, 12'($urandom)};
		end
		send_req(r_op, r_va, 20'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// drop valid and hold until every result is back
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic paging, input logic [31:0] offset);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PAGING_ON;
		cfg_wdata <= {31'b0, paging};
		@(posedge clk);
		cfg_index <= CFG_LOAD_OFFSET;
		cfg_wdata <= offset;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		out_ready <= 1'b0;
		rx_wait = 0;
		rx_count = 0;
		rx_held = 1'b0;
		wait (arst_n === 1'b1);
		rx_wait = $urandom_range(0, IDLE_MAX);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				rx_count++;
				if (!rx_held && rx_count == HOLD_AT) begin
					rx_held = 1'b1;
					rx_wait = LONG_HOLD;
				end else begin
					rx_wait = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
				end
				if (rx_wait != 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (rx_wait == 0)
					out_ready <= 1'b1;
				else
					rx_wait--;
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PAGING_ON;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = OP_TRANSLATE;
		vaddr = '0;
		frame_number = '0;
		rw_flag = 1'b0;
		user_flag = 1'b0;
		no_idle = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// paging off at reset values: offset subtraction, tables still written
		send_req(OP_TRANSLATE, 32'h0000_0000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_TRANSLATE, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, 1'b1);
		send_req(OP_UNMAP,     32'h0000_0000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_MAP,       32'h0000_0000, 20'hFFFFF, 1'b1, 1'b1);
		send_req(OP_MAP,       32'h0000_0000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_MAP,       32'hFFFF_FFFF, 20'hA5A5A, 1'b1, 1'b0);
		send_req(OP_UNUSED,    32'hFFFF_FFFF, 20'hFFFFF, 1'b1, 1'b1);
		send_req(OP_TRANSLATE, 32'hC000_0000, 20'h00000, 1'b0, 1'b0);
		drain();
		set_config(1'b1, 32'h0000_0000);
		send_req(OP_TRANSLATE, 32'h0000_0ABC, 20'h00000, 1'b0, 1'b0);
		send_req(OP_TRANSLATE, 32'hFFFF_FFFF, 20'h00000, 1'b0, 1'b0);
		send_req(OP_TRANSLATE, 32'h0040_0000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_TRANSLATE, 32'h0000_1000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_UNMAP,     32'h0000_1000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_UNMAP,     32'h0000_0000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_TRANSLATE, 32'h0000_0000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_MAP,       32'h003F_F000, 20'h12345, 1'b0, 1'b1);
		send_req(OP_TRANSLATE, 32'h003F_FFFF, 20'h00000, 1'b0, 1'b0);
		send_req(OP_UNUSED,    32'h0000_0000, 20'h00000, 1'b0, 1'b0);
		drain();
		set_config(1'b0, 32'hFFFF_FFFF);
		send_req(OP_TRANSLATE, 32'h0000_0000, 20'h00000, 1'b0, 1'b0);
		send_req(OP_TRANSLATE, 32'hFFFF_FFFF, 20'h00000, 1'b0, 1'b0);
		drain();
		set_config(1'b0, 32'h0000_0000);
		send_req(OP_TRANSLATE, 32'h1234_5678, 20'h00000, 1'b0, 1'b0);

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
			0: set_config(1'b1, $urandom);
			1: set_config(1'b1, 32'h0000_0000);
			2: set_config(1'b0, $urandom);
			default: set_config(1'b1, 32'hFFFF_FFFF);
			endcase
			no_idle = (phase == 1);
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_random();
		end
		no_idle = 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
src/tlpt_pkg.sv
src/tlpt_ram.sv
src/two_level_page_table_engine.sv
tb/page_walk_checker.sv
tb/tb_top.sv
